// File: rtl/bgp_pkg.sv
`timescale 1ns / 1ps
package bgp_pkg;

   localparam int COORD_BITS_DEFAULT = 10;
   localparam int CHAN_BITS = 8;
   localparam int NUM_CHAN = 3;
   localparam int SIZE_BITS = 11;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = NUM_CHAN * CHAN_BITS;

   // Quotient bits resolved per divider stage.
   localparam int DIV_STEP_BITS = 2;
   localparam int DIV_STAGES = CHAN_BITS / DIV_STEP_BITS;

   // Cycles the free-running step dividers need after a register changes.
   localparam int SETTLE_CYCLES = DIV_STAGES;

   // One RGB triple: index 2 is red, 1 is green, 0 is blue.
   typedef logic [NUM_CHAN-1:0][CHAN_BITS-1:0] pixel_type;

   localparam logic [SIZE_BITS-1:0] FILL_WIDTH_RESET = 11'd80;
   localparam logic [SIZE_BITS-1:0] FILL_HEIGHT_RESET = 11'd20;
   localparam pixel_type TOP_LEFT_RESET = 24'hFF0000;
   localparam pixel_type TOP_RIGHT_RESET = 24'h00FF00;
   localparam pixel_type BOTTOM_LEFT_RESET = 24'h0000FF;
   localparam pixel_type BOTTOM_RIGHT_RESET = 24'hFFFFFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FILL_WIDTH         = 3'd0,
      REG_FILL_HEIGHT        = 3'd1,
      REG_TOP_LEFT_COLOR     = 3'd2,
      REG_TOP_RIGHT_COLOR    = 3'd3,
      REG_BOTTOM_LEFT_COLOR  = 3'd4,
      REG_BOTTOM_RIGHT_COLOR = 3'd5
   } csr_index_type;

   // Settings and derived steps handed from the register block to the pixel pipeline.
   typedef struct packed {
      logic [SIZE_BITS-1:0] fill_width;
      logic [SIZE_BITS-1:0] fill_height;
      pixel_type            top_left;
      pixel_type            bottom_left;
      pixel_type            top_step;
      pixel_type            bottom_step;
      logic [SIZE_BITS-1:0] vert_divisor;
      logic                 vert_zero;
      logic                 busy;
   } cfg_type;

   function automatic logic [CHAN_BITS-1:0] abs_diff(input logic [CHAN_BITS-1:0] a,
                                                     input logic [CHAN_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

// File: rtl/bgp_req_if.sv
`timescale 1ns / 1ps
interface bgp_req_if #(
   parameter int COORD_BITS = bgp_pkg::COORD_BITS_DEFAULT
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_row;
   logic [COORD_BITS-1:0] pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink (input valid, input pixel_row, input pixel_col, output ready);
endinterface

// File: rtl/bgp_rsp_if.sv
`timescale 1ns / 1ps
interface bgp_rsp_if ();
   logic                           valid;
   logic                           ready;
   logic [bgp_pkg::CHAN_BITS-1:0]  red_value;
   logic [bgp_pkg::CHAN_BITS-1:0]  green_value;
   logic [bgp_pkg::CHAN_BITS-1:0]  blue_value;
   logic                           outside_area;

   modport source (output valid, output red_value, output green_value, output blue_value,
                   output outside_area, input ready);
   modport sink (input valid, input red_value, input green_value, input blue_value,
                 input outside_area, output ready);
endinterface

// File: rtl/bgp_div.sv
`timescale 1ns / 1ps
module bgp_div (
   input  logic                           clock,
   input  logic [bgp_pkg::DIV_STAGES-1:0] stage_load,
   input  logic [bgp_pkg::CHAN_BITS-1:0]  dividend_mag,
   input  logic                           dividend_neg,
   input  logic                           quot_zero,
   input  logic [bgp_pkg::SIZE_BITS-1:0]  divisor,
   output logic [bgp_pkg::CHAN_BITS-1:0]  quot_lo
);
   localparam int STAGES = bgp_pkg::DIV_STAGES;
   localparam int W = bgp_pkg::CHAN_BITS;
   localparam int RW = bgp_pkg::SIZE_BITS;
   localparam int STEP = bgp_pkg::DIV_STEP_BITS;

   logic [RW-1:0] rem_ff  [STAGES];
   logic [W-1:0]  num_ff  [STAGES];
   logic [W-1:0]  quo_ff  [STAGES];
   logic          neg_ff  [STAGES];
   logic          zero_ff [STAGES];

   logic [RW-1:0] rem_in  [STAGES];
   logic [W-1:0]  num_in  [STAGES];
   logic [W-1:0]  quo_in  [STAGES];

   logic [RW-1:0] rem_src  [STAGES];
   logic [W-1:0]  num_src  [STAGES];
   logic [W-1:0]  quo_src  [STAGES];
   logic          neg_src  [STAGES];
   logic          zero_src [STAGES];

   assign rem_src[0] = '0;
   assign num_src[0] = dividend_mag;
   assign quo_src[0] = '0;
   assign neg_src[0] = dividend_neg;
   assign zero_src[0] = quot_zero;

   for (genvar s = 1; s < STAGES; s++) begin : g_src
      assign rem_src[s] = rem_ff[s-1];
      assign num_src[s] = num_ff[s-1];
      assign quo_src[s] = quo_ff[s-1];
      assign neg_src[s] = neg_ff[s-1];
      assign zero_src[s] = zero_ff[s-1];
   end

   // Restoring division: the remainder stays below the divisor, so it fits RW bits.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      always_comb begin
         logic [RW:0]   trial;
         logic [RW-1:0] r;
         logic [W-1:0]  n;
         logic [W-1:0]  q;
         r = rem_src[s];
         n = num_src[s];
         q = quo_src[s];
         for (int k = 0; k < STEP; k++) begin
            trial = {r, n[W-1]};
            if (trial >= {1'b0, divisor}) begin
               r = RW'(trial - {1'b0, divisor});
               q = {q[W-2:0], 1'b1};
            end else begin
               r = trial[RW-1:0];
               q = {q[W-2:0], 1'b0};
            end
            n = {n[W-2:0], 1'b0};
         end
         rem_in[s] = r;
         num_in[s] = n;
         quo_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (stage_load[s]) begin
            rem_ff[s] <= rem_in[s];
            num_ff[s] <= num_in[s];
            quo_ff[s] <= quo_in[s];
            neg_ff[s] <= neg_src[s];
            zero_ff[s] <= zero_src[s];
         end
      end
   end

   // Only the low bits of the signed quotient matter downstream, as all sums wrap mod 256.
   always_comb begin
      if (zero_ff[STAGES-1]) begin
         quot_lo = '0;
      end else if (neg_ff[STAGES-1]) begin
         quot_lo = ~quo_ff[STAGES-1] + 1'b1;
      end else begin
         quot_lo = quo_ff[STAGES-1];
      end
   end

endmodule

// File: rtl/bgp_cfg.sv
`timescale 1ns / 1ps
module bgp_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bgp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bgp_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output bgp_pkg::cfg_type                   cfg
);
   localparam int NCH = bgp_pkg::NUM_CHAN;
   localparam int W = bgp_pkg::CHAN_BITS;
   localparam int SW = bgp_pkg::SIZE_BITS;
   localparam int CNT_W = $clog2(bgp_pkg::SETTLE_CYCLES + 1);

   logic [SW-1:0]      width_ff;
   logic [SW-1:0]      height_ff;
   bgp_pkg::pixel_type top_left_ff;
   bgp_pkg::pixel_type top_right_ff;
   bgp_pkg::pixel_type bottom_left_ff;
   bgp_pkg::pixel_type bottom_right_ff;
   logic [CNT_W-1:0]   settle_ff;

   logic [W-1:0]       top_q [NCH];
   logic [W-1:0]       bottom_q [NCH];
   logic               horiz_zero;
   logic [SW-1:0]      horiz_divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= bgp_pkg::FILL_WIDTH_RESET;
         height_ff <= bgp_pkg::FILL_HEIGHT_RESET;
         top_left_ff <= bgp_pkg::TOP_LEFT_RESET;
         top_right_ff <= bgp_pkg::TOP_RIGHT_RESET;
         bottom_left_ff <= bgp_pkg::BOTTOM_LEFT_RESET;
         bottom_right_ff <= bgp_pkg::BOTTOM_RIGHT_RESET;
         settle_ff <= CNT_W'(bgp_pkg::SETTLE_CYCLES);
      end else begin
         if (csr_we) begin
            settle_ff <= CNT_W'(bgp_pkg::SETTLE_CYCLES);
            unique case (bgp_pkg::csr_index_type'(csr_index))
               bgp_pkg::REG_FILL_WIDTH: width_ff <= csr_data[SW-1:0];
               bgp_pkg::REG_FILL_HEIGHT: height_ff <= csr_data[SW-1:0];
               bgp_pkg::REG_TOP_LEFT_COLOR: top_left_ff <= csr_data;
               bgp_pkg::REG_TOP_RIGHT_COLOR: top_right_ff <= csr_data;
               bgp_pkg::REG_BOTTOM_LEFT_COLOR: bottom_left_ff <= csr_data;
               bgp_pkg::REG_BOTTOM_RIGHT_COLOR: bottom_right_ff <= csr_data;
               default: ;
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
      end
   end

   // A fill size below two has no step along that axis.
   assign horiz_zero = (width_ff < SW'(2));
   assign horiz_divisor = width_ff - 1'b1;

   // The column steps depend only on the registers, so these dividers run freely.
   for (genvar ch = 0; ch < NCH; ch++) begin : g_chan
      bgp_div u_top_div (
         .clock        (clock),
         .stage_load   ('1),
         .dividend_mag (bgp_pkg::abs_diff(top_right_ff[ch], top_left_ff[ch])),
         .dividend_neg (top_right_ff[ch] < top_left_ff[ch]),
         .quot_zero    (horiz_zero),
         .divisor      (horiz_divisor),
         .quot_lo      (top_q[ch])
      );

      bgp_div u_bottom_div (
         .clock        (clock),
         .stage_load   ('1),
         .dividend_mag (bgp_pkg::abs_diff(bottom_right_ff[ch], bottom_left_ff[ch])),
         .dividend_neg (bottom_right_ff[ch] < bottom_left_ff[ch]),
         .quot_zero    (horiz_zero),
         .divisor      (horiz_divisor),
         .quot_lo      (bottom_q[ch])
      );
   end

   always_comb begin
      cfg.fill_width = width_ff;
      cfg.fill_height = height_ff;
      cfg.top_left = top_left_ff;
      cfg.bottom_left = bottom_left_ff;
      for (int ch = 0; ch < NCH; ch++) begin
         cfg.top_step[ch] = top_q[ch];
         cfg.bottom_step[ch] = bottom_q[ch];
      end
      cfg.vert_divisor = height_ff - 1'b1;
      cfg.vert_zero = (height_ff < SW'(2));
      cfg.busy = (settle_ff != '0);
   end

endmodule

// File: rtl/bgp_pixel.sv
`timescale 1ns / 1ps
module bgp_pixel #(
   parameter int COORD_BITS = bgp_pkg::COORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   bgp_req_if.sink          req_chan,
   bgp_rsp_if.source        rsp_chan,
   input  bgp_pkg::cfg_type cfg
);
   localparam int NCH = bgp_pkg::NUM_CHAN;
   localparam int W = bgp_pkg::CHAN_BITS;
   localparam int SW = bgp_pkg::SIZE_BITS;
   localparam int DSTG = bgp_pkg::DIV_STAGES;
   localparam int CMP_W = (COORD_BITS > SW) ? COORD_BITS : SW;
   localparam int EXT_W = COORD_BITS + W;

   localparam int ST_IN = 0;
   localparam int ST_EDGE = 1;
   localparam int ST_DIFF = 2;
   localparam int ST_DIV = 3;
   localparam int ST_OUT = ST_DIV + DSTG;
   localparam int NUM_ST = ST_OUT + 1;

   function automatic logic [W-1:0] mul_lo(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [2*W-1:0] p;
      p = a * b;
      return p[W-1:0];
   endfunction

   logic [NUM_ST-1:0] valid_ff;
   logic [NUM_ST-1:0] hold;
   logic [NUM_ST-1:0] load;
   logic              accept;

   logic [EXT_W-1:0]  row_ext;
   logic [EXT_W-1:0]  col_ext;
   logic              outside_now;

   // Input stage.
   logic [W-1:0]       row_in_ff;
   logic [W-1:0]       col_in_ff;
   logic               outside_in_ff;
   // Edge stage.
   logic [W-1:0]       row_edge_ff;
   bgp_pkg::pixel_type top_edge_ff;
   bgp_pkg::pixel_type bottom_edge_ff;
   logic               outside_edge_ff;
   // Difference stage.
   logic [W-1:0]       row_diff_ff;
   bgp_pkg::pixel_type top_diff_ff;
   bgp_pkg::pixel_type vmag_diff_ff;
   logic [NCH-1:0]     vneg_diff_ff;
   logic               outside_diff_ff;
   // Side data that rides along the divider stages.
   logic [W-1:0]       row_div_ff [DSTG];
   bgp_pkg::pixel_type top_div_ff [DSTG];
   logic               outside_div_ff [DSTG];
   // Output register.
   bgp_pkg::pixel_type color_ff;
   logic               outside_out_ff;

   logic [W-1:0]       vert_q [NCH];

   // A stage holds only when it is full and the stage after it holds; bubbles collapse.
   always_comb begin
      hold[NUM_ST-1] = valid_ff[NUM_ST-1] & ~rsp_chan.ready;
      for (int s = NUM_ST - 2; s >= 0; s--) begin
         hold[s] = valid_ff[s] & hold[s+1];
      end
      load = ~hold;
   end

   assign req_chan.ready = ~hold[ST_IN] & ~cfg.busy;
   assign accept = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[ST_IN]) begin
            valid_ff[ST_IN] <= accept;
         end
         for (int s = 1; s < NUM_ST; s++) begin
            if (load[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   assign row_ext = EXT_W'(req_chan.pixel_row);
   assign col_ext = EXT_W'(req_chan.pixel_col);
   assign outside_now = (CMP_W'(req_chan.pixel_row) >= CMP_W'(cfg.fill_height))
                     || (CMP_W'(req_chan.pixel_col) >= CMP_W'(cfg.fill_width));

   always_ff @(posedge clock) begin
      if (load[ST_IN]) begin
         row_in_ff <= row_ext[W-1:0];
         col_in_ff <= col_ext[W-1:0];
         outside_in_ff <= outside_now;
      end
   end

   // Inside the area both edge values land between their corners, so 8 bits hold them exactly.
   always_ff @(posedge clock) begin
      if (load[ST_EDGE]) begin
         row_edge_ff <= row_in_ff;
         outside_edge_ff <= outside_in_ff;
         for (int ch = 0; ch < NCH; ch++) begin
            top_edge_ff[ch] <= cfg.top_left[ch] + mul_lo(cfg.top_step[ch], col_in_ff);
            bottom_edge_ff[ch] <= cfg.bottom_left[ch] + mul_lo(cfg.bottom_step[ch], col_in_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_DIFF]) begin
         row_diff_ff <= row_edge_ff;
         top_diff_ff <= top_edge_ff;
         outside_diff_ff <= outside_edge_ff;
         for (int ch = 0; ch < NCH; ch++) begin
            vmag_diff_ff[ch] <= bgp_pkg::abs_diff(bottom_edge_ff[ch], top_edge_ff[ch]);
            vneg_diff_ff[ch] <= (bottom_edge_ff[ch] < top_edge_ff[ch]);
         end
      end
   end

   for (genvar ch = 0; ch < NCH; ch++) begin : g_vdiv
      bgp_div u_vert_div (
         .clock        (clock),
         .stage_load   (load[ST_DIV +: DSTG]),
         .dividend_mag (vmag_diff_ff[ch]),
         .dividend_neg (vneg_diff_ff[ch]),
         .quot_zero    (cfg.vert_zero),
         .divisor      (cfg.vert_divisor),
         .quot_lo      (vert_q[ch])
      );
   end

   for (genvar s = 0; s < DSTG; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (load[ST_DIV]) begin
               row_div_ff[s] <= row_diff_ff;
               top_div_ff[s] <= top_diff_ff;
               outside_div_ff[s] <= outside_diff_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (load[ST_DIV + s]) begin
               row_div_ff[s] <= row_div_ff[s-1];
               top_div_ff[s] <= top_div_ff[s-1];
               outside_div_ff[s] <= outside_div_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         outside_out_ff <= outside_div_ff[DSTG-1];
         for (int ch = 0; ch < NCH; ch++) begin
            if (outside_div_ff[DSTG-1]) begin
               color_ff[ch] <= '0;
            end else begin
               color_ff[ch] <= top_div_ff[DSTG-1][ch] + mul_lo(vert_q[ch], row_div_ff[DSTG-1]);
            end
         end
      end
   end

   assign rsp_chan.valid = valid_ff[ST_OUT];
   assign rsp_chan.red_value = color_ff[2];
   assign rsp_chan.green_value = color_ff[1];
   assign rsp_chan.blue_value = color_ff[0];
   assign rsp_chan.outside_area = outside_out_ff;

endmodule

// File: rtl/bilinear_gradient_pixel_top.sv
`timescale 1ns / 1ps
// A request passes input, edge, difference, divider and output stages. Throughput: one pixel
// per cycle while rsp_chan is ready and steps are settled, set by the 8-stage pipeline with
// 2-bit divider stages. After reset and every register write, req_chan.ready stays low while
// the column step dividers, one 4-stage divider per corner pair and channel, settle.
// Reset is synchronous and active high; it empties the pipeline and loads register defaults.
module bilinear_gradient_pixel_top #(
   parameter int COORD_BITS = bgp_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   bgp_req_if.sink                            req_chan,
   bgp_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [bgp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bgp_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   bgp_pkg::cfg_type cfg;

   bgp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bgp_pixel #(
      .COORD_BITS (COORD_BITS)
   ) u_pixel (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cfg      (cfg)
   );

   // A register write must hold off new pixels until the steps are recomputed.
   a_write_blocks_requests: assert property (
      @(posedge clock) disable iff (reset)
      csr_we |=> !req_chan.ready
   ) else $error("request accepted right after a register write");

   a_outside_is_black: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.outside_area) |->
         (rsp_chan.red_value == '0 && rsp_chan.green_value == '0 && rsp_chan.blue_value == '0)
   ) else $error("pixel outside the area carries a color");

   // With an empty output register and settled steps the pipeline must take a transaction.
   a_ready_when_free: assert property (
      @(posedge clock) disable iff (reset)
      (!rsp_chan.valid && !cfg.busy) |-> req_chan.ready
   ) else $error("pipeline stalls with nothing waiting at the output");

   a_reset_empties: assert property (
      @(posedge clock)
      reset |=> !rsp_chan.valid
   ) else $error("response valid right after reset");

endmodule
